/* hdl/itoa_fmt_pkg.sv */
// Shared types, constants and helpers for the integer-to-ASCII field formatter.
// No dependencies; imported by every module of the block.
package itoa_fmt_pkg;

  // Field width limit; pad_width above it is clipped.
  localparam int MAX_WIDTH = 32;
  localparam int WW        = $clog2(MAX_WIDTH + 1);

  // Request modes
  localparam logic [2:0] MODE_SDEC = 3'd0;
  localparam logic [2:0] MODE_UDEC = 3'd1;
  localparam logic [2:0] MODE_HEXL = 3'd2;
  localparam logic [2:0] MODE_HEXU = 3'd3;
  localparam logic [2:0] MODE_PTR  = 3'd4;

  // ASCII codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_LA    = 8'h61;

  // Descriptor queue
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    PRE_NONE,
    PRE_MINUS,
    PRE_HEX
  } prefix_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_LPAD,
    B_SIGN,
    B_ZERO,
    B_X,
    B_DIG,
    B_TPAD
  } back_state_t;

  // One formatted field, ready to be emitted
  typedef struct packed {
    logic [63:0]   digits;  // 16 nibbles, BCD or hex
    logic [4:0]    nd;      // number of significant digits, 1..16
    prefix_t       pre;
    logic          upper;
    logic          left;
    logic [WW-1:0] pad;     // number of padding spaces
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
    logic [7:0] base;
    begin
      base = upper ? CH_UA : CH_LA;
      if (nib < 4'd10)
        digit_char = CH_ZERO + {4'b0, nib};
      else
        digit_char = base + {4'b0, nib} - 8'd10;
    end
  endfunction

endpackage

/* hdl/itoa_fmt_queue.sv */
// Two-entry descriptor queue between the front (conversion) and back (emit) parts.
// Depends on itoa_fmt_pkg.
module itoa_fmt_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  itoa_fmt_pkg::desc_t  push_desc,
  input  logic                 pop,
  output itoa_fmt_pkg::desc_t  head_desc,
  output itoa_fmt_pkg::q_stat_t qst
);
  import itoa_fmt_pkg::*;

  desc_t          mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, wp_nxt;
  logic [QAW-1:0] rp_r, rp_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign qst.full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign qst.empty = (cnt_r == '0);
  assign do_push   = push && !qst.full;
  assign do_pop    = pop && !qst.empty;
  assign head_desc = mem_r[rp_r];

  always_comb begin
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push)
      mem_r[wp_r] <= push_desc;
  end

endmodule

/* hdl/itoa_fmt_front.sv */
// Front part: takes a request, converts decimal values to BCD bit-serially,
// sizes the field and hands a descriptor to the queue. Depends on itoa_fmt_pkg.
module itoa_fmt_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            in_mode,
  input  logic [63:0]           in_value,
  input  logic [5:0]            in_pad_width,
  input  logic                  in_left_align,
  input  itoa_fmt_pkg::q_stat_t qst,
  output logic                  push,
  output itoa_fmt_pkg::desc_t   push_desc
);
  import itoa_fmt_pkg::*;

  localparam logic [4:0] CONV_LAST = 5'd31;
  localparam logic [6:0] MAXW7     = 7'(MAX_WIDTH);

  front_state_t  st_r, st_nxt;
  logic [31:0]   sh_r, sh_nxt;
  logic [4:0]    cnt_r, cnt_nxt;
  logic [63:0]   dig_r, dig_nxt;
  logic [2:0]    mode_r, mode_nxt;
  logic          neg_r, neg_nxt;
  logic          left_r, left_nxt;
  logic [WW-1:0] wid_r, wid_nxt;

  logic [31:0]   lo;
  logic [6:0]    pw7, wsat;
  logic [4:0]    nd, tlen;
  logic [1:0]    prelen;
  prefix_t       pre;
  logic          padded;

  // Add-3 correction on each BCD digit, then shift in the next binary bit
  function automatic logic [39:0] dabble(input logic [39:0] bcd, input logic b);
    logic [39:0] adj;
    begin
      adj = bcd;
      for (int d = 0; d < 10; d++) begin
        if (bcd[d*4 +: 4] >= 4'd5)
          adj[d*4 +: 4] = bcd[d*4 +: 4] + 4'd3;
      end
      dabble = {adj[38:0], b};
    end
  endfunction

  function automatic logic [4:0] count_digits(input logic [63:0] dig);
    logic [4:0] n;
    begin
      n = 5'd1;
      for (int k = 0; k < 16; k++) begin
        if (dig[k*4 +: 4] != 4'd0)
          n = 5'(k + 1);
      end
      count_digits = n;
    end
  endfunction

  assign busy = (st_r != F_IDLE);
  assign lo   = in_value[31:0];
  assign pw7  = {1'b0, in_pad_width};
  assign wsat = (pw7 > MAXW7) ? MAXW7 : pw7;

  // Size the field from the finished digits
  always_comb begin
    nd     = count_digits(dig_r);
    padded = (mode_r == MODE_SDEC) || (mode_r == MODE_UDEC);
    if (mode_r == MODE_PTR) begin
      pre    = PRE_HEX;
      prelen = 2'd2;
    end else if (neg_r) begin
      pre    = PRE_MINUS;
      prelen = 2'd1;
    end else begin
      pre    = PRE_NONE;
      prelen = 2'd0;
    end
    tlen             = nd + {3'b0, prelen};
    push_desc.digits = dig_r;
    push_desc.nd     = nd;
    push_desc.pre    = pre;
    push_desc.upper  = (mode_r == MODE_HEXU);
    push_desc.left   = left_r;
    push_desc.pad    = (padded && (wid_r > WW'(tlen))) ? wid_r - WW'(tlen) : '0;
  end

  always_comb begin
    st_nxt   = st_r;
    sh_nxt   = sh_r;
    cnt_nxt  = cnt_r;
    dig_nxt  = dig_r;
    mode_nxt = mode_r;
    neg_nxt  = neg_r;
    left_nxt = left_r;
    wid_nxt  = wid_r;
    push     = 1'b0;
    case (st_r)
      F_IDLE: begin
        if (start) begin
          mode_nxt = in_mode;
          left_nxt = in_left_align;
          wid_nxt  = WW'(wsat);
          neg_nxt  = (in_mode == MODE_SDEC) && lo[31];
          case (in_mode) inside
            MODE_SDEC, MODE_UDEC: begin
              sh_nxt  = ((in_mode == MODE_SDEC) && lo[31]) ? (~lo + 32'd1) : lo;
              dig_nxt = '0;
              cnt_nxt = '0;
              st_nxt  = F_CONV;
            end
            MODE_HEXL, MODE_HEXU: begin
              dig_nxt = {32'b0, lo};
              st_nxt  = F_PUSH;
            end
            MODE_PTR: begin
              dig_nxt = in_value;
              st_nxt  = F_PUSH;
            end
            default: begin
              // unused mode: drop the request
              st_nxt = F_IDLE;
            end
          endcase
        end
      end
      F_CONV: begin
        dig_nxt = {24'b0, dabble(dig_r[39:0], sh_r[31])};
        sh_nxt  = {sh_r[30:0], 1'b0};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == CONV_LAST)
          st_nxt = F_PUSH;
      end
      F_PUSH: begin
        // hold until the queue has room
        if (!qst.full) begin
          push   = 1'b1;
          st_nxt = F_IDLE;
        end
      end
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      st_r <= F_IDLE;
    else
      st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    sh_r   <= sh_nxt;
    cnt_r  <= cnt_nxt;
    dig_r  <= dig_nxt;
    mode_r <= mode_nxt;
    neg_r  <= neg_nxt;
    left_r <= left_nxt;
    wid_r  <= wid_nxt;
  end

endmodule

/* hdl/itoa_fmt_back.sv */
// Back part: pops descriptors and emits the field one character per cycle.
// Depends on itoa_fmt_pkg.
module itoa_fmt_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  itoa_fmt_pkg::q_stat_t qst,
  input  itoa_fmt_pkg::desc_t   head_desc,
  output logic                  pop,
  output logic                  out_strobe,
  output logic [7:0]            out_character,
  output logic                  out_last
);
  import itoa_fmt_pkg::*;

  back_state_t   st_r, st_nxt;
  desc_t         wk_r, wk_nxt;
  logic [WW-1:0] pcnt_r, pcnt_nxt;
  logic [3:0]    didx_r, didx_nxt;
  logic          strobe_r, strobe_nxt;
  logic [7:0]    char_r, char_nxt;
  logic          last_r, last_nxt;

  logic          tpad;

  function automatic back_state_t prefix_start(input desc_t d);
    begin
      case (d.pre)
        PRE_MINUS: prefix_start = B_SIGN;
        PRE_HEX:   prefix_start = B_ZERO;
        default:   prefix_start = B_DIG;
      endcase
    end
  endfunction

  assign out_strobe    = strobe_r;
  assign out_character = char_r;
  assign out_last      = last_r;
  assign tpad          = wk_r.left && (wk_r.pad != '0);

  always_comb begin
    st_nxt     = st_r;
    wk_nxt     = wk_r;
    pcnt_nxt   = pcnt_r;
    didx_nxt   = didx_r;
    pop        = 1'b0;
    strobe_nxt = 1'b0;
    char_nxt   = char_r;
    last_nxt   = 1'b0;
    case (st_r)
      B_IDLE: begin
        if (!qst.empty) begin
          pop      = 1'b1;
          wk_nxt   = head_desc;
          pcnt_nxt = head_desc.pad;
          didx_nxt = 4'(head_desc.nd - 5'd1);
          if (!head_desc.left && (head_desc.pad != '0))
            st_nxt = B_LPAD;
          else
            st_nxt = prefix_start(head_desc);
        end
      end
      B_LPAD: begin
        strobe_nxt = 1'b1;
        char_nxt   = CH_SPACE;
        pcnt_nxt   = pcnt_r - WW'(1);
        if (pcnt_r == WW'(1))
          st_nxt = prefix_start(wk_r);
      end
      B_SIGN: begin
        strobe_nxt = 1'b1;
        char_nxt   = CH_MINUS;
        st_nxt     = B_DIG;
      end
      B_ZERO: begin
        strobe_nxt = 1'b1;
        char_nxt   = CH_ZERO;
        st_nxt     = B_X;
      end
      B_X: begin
        strobe_nxt = 1'b1;
        char_nxt   = CH_X;
        st_nxt     = B_DIG;
      end
      B_DIG: begin
        strobe_nxt = 1'b1;
        char_nxt   = digit_char(wk_r.digits[didx_r*4 +: 4], wk_r.upper);
        didx_nxt   = didx_r - 4'd1;
        if (didx_r == 4'd0) begin
          last_nxt = !tpad;
          pcnt_nxt = wk_r.pad;
          st_nxt   = tpad ? B_TPAD : B_IDLE;
        end
      end
      B_TPAD: begin
        strobe_nxt = 1'b1;
        char_nxt   = CH_SPACE;
        pcnt_nxt   = pcnt_r - WW'(1);
        if (pcnt_r == WW'(1)) begin
          last_nxt = 1'b1;
          st_nxt   = B_IDLE;
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= B_IDLE;
      strobe_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wk_r   <= wk_nxt;
    pcnt_r <= pcnt_nxt;
    didx_r <= didx_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

endmodule

/* hdl/integer_to_ascii_field_formatter.sv */
// Top level of the integer-to-ASCII field formatter: front, descriptor queue, back.
// Depends on itoa_fmt_pkg, itoa_fmt_front, itoa_fmt_queue, itoa_fmt_back.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-------------------------------------------
//   request  | start in, busy out      | in_mode, in_value, in_pad_width, in_left_align
//   result   | out_strobe out          | out_character, out_last
//
// A request is taken when start is high and busy is low. After the transfer a
// decimal request keeps busy high through F_CONV (the bit-serial BCD converter)
// and F_PUSH (queueing); hex and pointer requests go straight to F_PUSH.
// Busy also stays high while the two-entry queue is full. The back picks up a
// descriptor in B_IDLE, then emits one registered character per cycle
// (up to MAX_WIDTH per field), so conversion of the next request overlaps emission.
// Synchronous active-low reset empties the queue and idles both parts.
// Results carry a one-cycle strobe and are never held off by the receiver.
module integer_to_ascii_field_formatter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_mode,
  input  logic [63:0] in_value,
  input  logic [5:0]  in_pad_width,
  input  logic        in_left_align,
  output logic        out_strobe,
  output logic [7:0]  out_character,
  output logic        out_last
);
  import itoa_fmt_pkg::*;

  desc_t   push_desc, head_desc;
  q_stat_t qst;
  logic    push, pop;

  itoa_fmt_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_mode       (in_mode),
    .in_value      (in_value),
    .in_pad_width  (in_pad_width),
    .in_left_align (in_left_align),
    .qst           (qst),
    .push          (push),
    .push_desc     (push_desc)
  );

  itoa_fmt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head_desc (head_desc),
    .qst       (qst)
  );

  itoa_fmt_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .qst           (qst),
    .head_desc     (head_desc),
    .pop           (pop),
    .out_strobe    (out_strobe),
    .out_character (out_character),
    .out_last      (out_last)
  );

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for integer_to_ascii_field_formatter.
// Depends on itoa_fmt_pkg and the formatter RTL; predicts every character in-bench.
module tb;
  import itoa_fmt_pkg::*;

  localparam logic [2:0] MODE_RSVD5 = 3'd5;
  localparam logic [2:0] MODE_RSVD6 = 3'd6;
  localparam logic [2:0] MODE_RSVD7 = 3'd7;

  localparam int    RANDOM_ITEMS = 106;
  localparam int    DRAIN_CYCLES = 80;
  localparam int    STALL_LIMIT  = 1000;
  localparam int    MAX_REPORTS  = 100;
  localparam string HEX_SET_LO   = "0123456789abcdef";
  localparam string HEX_SET_HI   = "0123456789ABCDEF";

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } field_char_t;

  // typed rows carry their exact text; the rest go through the predictor
  typedef struct {
    logic [2:0]  mode;
    logic [63:0] value;
    logic [5:0]  pad_width;
    logic        left;
    bit          typed;
    string       text;
  } request_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_mode;
  logic [63:0] in_value;
  logic [5:0]  in_pad_width;
  logic        in_left_align;
  logic        out_strobe;
  logic [7:0]  out_character;
  logic        out_last;

  field_char_t pending_chars[$];
  int          mismatches      = 0;
  int          requests_sent   = 0;
  int          chars_seen      = 0;
  int          quiet_cycles    = 0;
  int          sender_idle_pct = 0;

  request_row_t directed_rows[] = '{
    '{MODE_SDEC, 64'd0,                    6'd0,  1'b0, 1'b1, "0"},
    '{MODE_SDEC, 64'h0000_0000_8000_0000,  6'd0,  1'b0, 1'b1, "-2147483648"},
    '{MODE_SDEC, 64'h0000_0000_7fff_ffff,  6'd0,  1'b0, 1'b1, "2147483647"},
    '{MODE_SDEC, 64'hffff_ffff_ffff_ffff,  6'd0,  1'b0, 1'b1, "-1"},
    '{MODE_UDEC, 64'h0000_0000_ffff_ffff,  6'd0,  1'b0, 1'b1, "4294967295"},
    '{MODE_UDEC, 64'd0,                    6'd5,  1'b0, 1'b1, "    0"},
    '{MODE_UDEC, 64'd0,                    6'd5,  1'b1, 1'b1, "0    "},
    '{MODE_SDEC, 64'h0000_0000_ffff_fffb,  6'd4,  1'b1, 1'b1, "-5  "},
    '{MODE_UDEC, 64'd123,                  6'd63, 1'b0, 1'b0, ""},
    '{MODE_SDEC, 64'd123,                  6'd2,  1'b0, 1'b1, "123"},
    '{MODE_SDEC, 64'd123,                  6'd3,  1'b1, 1'b1, "123"},
    '{MODE_HEXL, 64'h0000_0000_dead_beef,  6'd10, 1'b0, 1'b1, "deadbeef"},
    '{MODE_HEXU, 64'h0000_0000_dead_beef,  6'd10, 1'b1, 1'b1, "DEADBEEF"},
    '{MODE_HEXL, 64'd0,                    6'd0,  1'b0, 1'b1, "0"},
    '{MODE_PTR,  64'd0,                    6'd20, 1'b0, 1'b1, "0x0"},
    '{MODE_PTR,  64'hffff_ffff_ffff_ffff,  6'd0,  1'b1, 1'b1, "0xffffffffffffffff"},
    '{MODE_PTR,  64'h0123_4567_89ab_cdef,  6'd0,  1'b0, 1'b1, "0x123456789abcdef"},
    '{MODE_HEXU, 64'hffff_ffff_0000_0000,  6'd0,  1'b0, 1'b1, "0"},
    '{MODE_RSVD5, 64'd42,                  6'd0,  1'b0, 1'b1, ""},
    '{MODE_RSVD6, 64'h8000_0000_0000_0000, 6'd32, 1'b1, 1'b1, ""},
    '{MODE_RSVD7, 64'hffff_ffff_ffff_ffff, 6'd63, 1'b1, 1'b1, ""},
    '{MODE_UDEC, 64'haaaa_aaaa_aaaa_aaaa,  6'd32, 1'b1, 1'b0, ""},
    '{MODE_SDEC, 64'h5555_5555_8000_0000,  6'd32, 1'b0, 1'b0, ""},
    '{MODE_UDEC, 64'd1,                    6'd1,  1'b0, 1'b1, "1"}
  };

  integer_to_ascii_field_formatter uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_mode       (in_mode),
    .in_value      (in_value),
    .in_pad_width  (in_pad_width),
    .in_left_align (in_left_align),
    .out_strobe    (out_strobe),
    .out_character (out_character),
    .out_last      (out_last)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  // Expand one request into the characters of its field, queued in output order.
  function automatic void predict_field(input logic [2:0] mode, input logic [63:0] value,
                                        input logic [5:0] pad_width, input logic left);
    logic [7:0]  text[$];
    logic [63:0] mag;
    logic [63:0] radix;
    logic [31:0] lo;
    int          width;
    int          pad;
    bit          pads;
    bit          upper;
    bit          neg;
    lo    = value[31:0];
    mag   = {32'd0, lo};
    radix = 64'd16;
    pads  = 1'b0;
    upper = 1'b0;
    neg   = 1'b0;
    width = (pad_width > MAX_WIDTH) ? MAX_WIDTH : int'(pad_width);
    case (mode)
      MODE_SDEC: begin
        radix = 64'd10;
        pads  = 1'b1;
        neg   = lo[31];
        if (neg) mag = {32'd0, -lo};
      end
      MODE_UDEC: begin
        radix = 64'd10;
        pads  = 1'b1;
      end
      MODE_HEXL: ;
      MODE_HEXU: upper = 1'b1;
      MODE_PTR:  mag = value;
      default:   return;
    endcase
    do begin
      text.push_front(upper ? HEX_SET_HI[mag % radix] : HEX_SET_LO[mag % radix]);
      mag = mag / radix;
    end while (mag != 0);
    if (neg) text.push_front(CH_MINUS);
    if (mode == MODE_PTR) begin
      text.push_front(CH_X);
      text.push_front(CH_ZERO);
    end
    pad = (pads && width > text.size()) ? width - text.size() : 0;
    if (left) begin
      repeat (pad) text.push_back(CH_SPACE);
    end else begin
      repeat (pad) text.push_front(CH_SPACE);
    end
    foreach (text[i]) pending_chars.push_back('{text[i], i == text.size() - 1});
  endfunction

  task automatic send_request(input request_row_t row);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    in_mode       <= row.mode;
    in_value      <= row.value;
    in_pad_width  <= row.pad_width;
    in_left_align <= row.left;
    @(posedge clk);
    while (busy) @(posedge clk);
    requests_sent++;
    if (row.typed) begin
      for (int i = 0; i < row.text.len(); i++) begin
        pending_chars.push_back('{row.text[i], i == row.text.len() - 1});
      end
    end else begin
      predict_field(row.mode, row.value, row.pad_width, row.left);
    end
  endtask

  // Hold off the sender until every queued character has come out.
  task automatic drain_fields();
    start <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    field_char_t want;
    if (rst_n) begin
      if ((start && !busy) || out_strobe) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: FAIL");
        $finish;
      end else if (out_strobe) begin
        chars_seen++;
        if (pending_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected character %h last %b",
                                    out_character, out_last));
        end else begin
          want = pending_chars.pop_front();
          if (out_character !== want.ch) begin
            report_mismatch($sformatf("character %h, want %h", out_character, want.ch));
          end
          if (out_last !== want.last) begin
            report_mismatch($sformatf("last %b, want %b (character %h)",
                                      out_last, want.last, want.ch));
          end
        end
      end
    end
  end

  initial begin
    request_row_t row;
    int           phase_idle[3];
    int           counted;
    phase_idle    = '{0, 70, 33};
    rst_n         = 1'b0;
    start         = 1'b0;
    in_mode       = MODE_SDEC;
    in_value      = 64'd0;
    in_pad_width  = 6'd0;
    in_left_align = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) send_request(directed_rows[i]);
    drain_fields();

    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = phase_idle[phase];
      counted = 0;
      while (counted < RANDOM_ITEMS / 3 + 1) begin
        row.typed = 1'b0;
        row.text  = "";
        if ($urandom_range(9) == 0) row.mode = 3'($urandom_range(MODE_RSVD7, MODE_RSVD5));
        else row.mode = 3'($urandom_range(MODE_PTR, MODE_SDEC));
        case ($urandom_range(3))
          0: row.value = {$urandom, $urandom};
          1: row.value = {($urandom_range(1) ? $urandom : 32'd0), 32'($urandom_range(999))};
          2: row.value = {$urandom, ($urandom_range(1) ? 32'h8000_0000 : 32'hffff_ff00)}
                         | 64'($urandom_range(255));
          default: row.value = {$urandom, 32'd0};
        endcase
        // mostly modest widths, now and then anything up to the port limit
        row.pad_width = ($urandom_range(3) == 0) ? 6'($urandom_range(63))
                                                 : 6'($urandom_range(12));
        row.left = 1'($urandom_range(1));
        send_request(row);
        counted++;
      end
      drain_fields();
    end

    if (pending_chars.size() != 0) begin
      report_mismatch($sformatf("%0d characters never came out", pending_chars.size()));
    end
    $display("tb: %0d requests (%0d directed) in all five modes plus unused ones,",
             requests_sent, directed_rows.size());
    $display("tb: widths 0..63 both alignments, sender idle 0/70/33%%; %0d characters, %0d bad",
             chars_seen, mismatches);
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
